>>> rtl/fwd_pkg.sv
// Package for the FLIC word delta decoder: phase encoding, action and status codes,
// and the result record passed from the decode core to the output stage.
// No dependencies.
`default_nettype none

package fwd_pkg;

    localparam int unsigned WidthBits = 16;
    localparam int unsigned AddrBits  = 32;

    typedef logic [1:0] t_action;
    localparam t_action ACT_NONE       = 2'd0;
    localparam t_action ACT_WRITE      = 2'd1;
    localparam t_action ACT_FILL_BYTES = 2'd2;
    localparam t_action ACT_FILL_WORDS = 2'd3;

    typedef logic [2:0] t_status;
    localparam t_status ST_OK    = 3'd0;
    localparam t_status ST_TRUNC = 3'd1;
    localparam t_status ST_ROW   = 3'd2;
    localparam t_status ST_COL   = 3'd3;
    localparam t_status ST_TAG   = 3'd4;

    typedef logic [1:0] t_tag;
    localparam t_tag TAG_PACKETS  = 2'b00;
    localparam t_tag TAG_BAD      = 2'b01;
    localparam t_tag TAG_LAST_COL = 2'b10;
    localparam t_tag TAG_ROW_SKIP = 2'b11;

    localparam logic [0:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [0:0] CFG_FRAME_HEIGHT = 1'd1;

    localparam logic [WidthBits-1:0] FrameWidthReset  = 16'd320;
    localparam logic [WidthBits-1:0] FrameHeightReset = 16'd200;

    typedef enum logic [10:0] {
        PH_CNT_LO  = 11'b000_0000_0001,
        PH_CNT_HI  = 11'b000_0000_0010,
        PH_OP_LO   = 11'b000_0000_0100,
        PH_OP_HI   = 11'b000_0000_1000,
        PH_SKIP    = 11'b000_0001_0000,
        PH_COUNT   = 11'b000_0010_0000,
        PH_LIT     = 11'b000_0100_0000,
        PH_FILL_LO = 11'b000_1000_0000,
        PH_FILL_HI = 11'b001_0000_0000,
        PH_DONE    = 11'b010_0000_0000,
        PH_ERR     = 11'b100_0000_0000
    } t_phase;

    typedef struct packed {
        logic                  has_result;
        t_action               action;
        logic [AddrBits-1:0]   address;
        logic [8:0]            run_length;
        logic [7:0]            low_byte;
        logic [7:0]            high_byte;
        logic                  chunk_end;
        t_status               status;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/fwd_in_if.sv
// Input channel of the FLIC word delta decoder: one payload byte per transfer.
// Depends on nothing.
`default_nettype none

interface fwd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       chunk_last;

    modport source (output valid, output payload_byte, output chunk_last, input ready);
    modport sink   (input valid, input payload_byte, input chunk_last, output ready);
endinterface

`default_nettype wire

>>> rtl/fwd_out_if.sv
// Output channel of the FLIC word delta decoder: one framebuffer command per transfer.
// Depends on nothing.
`default_nettype none

interface fwd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] address;
    logic [8:0]  run_length;
    logic [7:0]  low_byte;
    logic [7:0]  high_byte;
    logic        chunk_end;
    logic [2:0]  status;

    modport source (output valid, output action, output address, output run_length,
                    output low_byte, output high_byte, output chunk_end, output status,
                    input ready);
    modport sink   (input valid, input action, input address, input run_length,
                    input low_byte, input high_byte, input chunk_end, input status,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/fwd_core.sv
// Decode core of the FLIC word delta decoder: chunk parse state and per-byte decode.
// Depends on fwd_pkg.
`default_nettype none

module fwd_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_fire,
    input  wire logic [7:0]                        i_byte,
    input  wire logic                              i_last,
    input  wire logic [fwd_pkg::WidthBits-1:0]     i_frame_width,
    input  wire logic [fwd_pkg::WidthBits-1:0]     i_frame_height,
    output fwd_pkg::t_result                       o_result
);

    fwd_pkg::t_phase   r_phase, n_phase;
    logic [15:0]       r_lines_left, n_lines_left;
    logic [16:0]       r_row, n_row;
    logic [16:0]       r_column, n_column;
    logic [13:0]       r_packets_left, n_packets_left;
    logic [7:0]        r_held_byte, n_held_byte;
    logic [7:0]        r_signed_count, n_signed_count;
    logic [7:0]        r_literal_left, n_literal_left;
    fwd_pkg::t_status  r_error_code, n_error_code;

    logic [15:0]       op_word;
    fwd_pkg::t_tag     op_tag;
    logic [16:0]       row_inc;
    logic [15:0]       lines_dec;
    logic [13:0]       packets_dec;
    fwd_pkg::t_phase   line_phase;
    logic [17:0]       skip_row;
    logic [17:0]       skip_col;
    logic [8:0]        run_bytes;
    logic [17:0]       run_end;
    logic [8:0]        fill_words;
    logic [8:0]        fill_bytes;
    logic              row_bad;
    logic              use_last_col;
    logic [32:0]       row_base;
    logic [16:0]       col_term;
    logic [31:0]       here_addr;
    logic              emit;
    fwd_pkg::t_action  emit_action;
    logic [8:0]        emit_run;
    logic [7:0]        emit_low;
    logic [7:0]        emit_high;

    assign op_word     = {i_byte, r_held_byte};
    assign op_tag      = op_word[15:14];
    assign row_inc     = r_row + 17'd1;
    assign lines_dec   = r_lines_left - 16'd1;
    assign packets_dec = r_packets_left - 14'd1;
    assign line_phase  = (lines_dec != 16'd0) ? fwd_pkg::PH_OP_LO : fwd_pkg::PH_DONE;
    assign skip_row    = {1'b0, r_row} + (18'h10000 - {2'b00, op_word});
    assign skip_col    = {1'b0, r_column} + {10'd0, i_byte};
    assign run_bytes   = i_byte[7] ? 9'(10'h200 - {1'b0, i_byte, 1'b0})
                                   : {1'b0, i_byte[6:0], 1'b0};
    assign run_end     = {1'b0, r_column} + {9'd0, run_bytes};
    assign fill_words  = 9'h100 - {1'b0, r_signed_count};
    assign fill_bytes  = {fill_words[7:0], 1'b0};
    assign row_bad     = r_row >= {1'b0, i_frame_height};

    // Address: row * pitch + column, or the last column for a tagged store.
    assign use_last_col = (r_phase == fwd_pkg::PH_OP_HI);
    assign row_base     = 33'(r_row) * 33'(i_frame_width);
    assign col_term     = use_last_col ? {1'b0, i_frame_width - 16'd1} : r_column;
    assign here_addr    = 32'(row_base + {16'd0, col_term});

    always_comb begin
        n_phase        = r_phase;
        n_lines_left   = r_lines_left;
        n_row          = r_row;
        n_column       = r_column;
        n_packets_left = r_packets_left;
        n_held_byte    = r_held_byte;
        n_signed_count = r_signed_count;
        n_literal_left = r_literal_left;
        n_error_code   = r_error_code;
        emit           = 1'b0;
        emit_action    = fwd_pkg::ACT_NONE;
        emit_run       = 9'd0;
        emit_low       = 8'd0;
        emit_high      = 8'd0;

        unique case (r_phase)
            fwd_pkg::PH_CNT_LO: begin
                n_held_byte = i_byte;
                n_phase     = fwd_pkg::PH_CNT_HI;
            end
            fwd_pkg::PH_CNT_HI: begin
                n_lines_left = op_word;
                n_phase      = (op_word != 16'd0) ? fwd_pkg::PH_OP_LO : fwd_pkg::PH_DONE;
            end
            fwd_pkg::PH_OP_LO: begin
                n_held_byte = i_byte;
                n_phase     = fwd_pkg::PH_OP_HI;
            end
            fwd_pkg::PH_OP_HI: begin
                unique case (op_tag)
                    fwd_pkg::TAG_PACKETS: begin
                        if (row_bad) begin
                            n_error_code = fwd_pkg::ST_ROW;
                            n_phase      = fwd_pkg::PH_ERR;
                        end else begin
                            n_packets_left = op_word[13:0];
                            n_column       = 17'd0;
                            if (op_word[13:0] == 14'd0) begin
                                n_row        = row_inc;
                                n_lines_left = lines_dec;
                                n_phase      = line_phase;
                            end else begin
                                n_phase = fwd_pkg::PH_SKIP;
                            end
                        end
                    end
                    fwd_pkg::TAG_ROW_SKIP: begin
                        n_row = skip_row[16:0];
                        if (skip_row > {2'b00, i_frame_height}) begin
                            n_error_code = fwd_pkg::ST_ROW;
                            n_phase      = fwd_pkg::PH_ERR;
                        end else begin
                            n_phase = fwd_pkg::PH_OP_LO;
                        end
                    end
                    fwd_pkg::TAG_LAST_COL: begin
                        if (row_bad) begin
                            n_error_code = fwd_pkg::ST_ROW;
                            n_phase      = fwd_pkg::PH_ERR;
                        end else if (i_frame_width == 16'd0) begin
                            n_error_code = fwd_pkg::ST_COL;
                            n_phase      = fwd_pkg::PH_ERR;
                        end else begin
                            emit        = 1'b1;
                            emit_action = fwd_pkg::ACT_WRITE;
                            emit_run    = 9'd1;
                            emit_low    = r_held_byte;
                            n_phase     = fwd_pkg::PH_OP_LO;
                        end
                    end
                    fwd_pkg::TAG_BAD: begin
                        n_error_code = fwd_pkg::ST_TAG;
                        n_phase      = fwd_pkg::PH_ERR;
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
            fwd_pkg::PH_SKIP: begin
                n_column = skip_col[16:0];
                if (skip_col > {2'b00, i_frame_width}) begin
                    n_error_code = fwd_pkg::ST_COL;
                    n_phase      = fwd_pkg::PH_ERR;
                end else begin
                    n_phase = fwd_pkg::PH_COUNT;
                end
            end
            fwd_pkg::PH_COUNT: begin
                n_signed_count = i_byte;
                if (i_byte == 8'd0) begin
                    n_packets_left = packets_dec;
                    if (packets_dec == 14'd0) begin
                        n_row        = row_inc;
                        n_lines_left = lines_dec;
                        n_phase      = line_phase;
                    end else begin
                        n_phase = fwd_pkg::PH_SKIP;
                    end
                end else if ((r_column <= {1'b0, i_frame_width})
                             && (run_end > {2'b00, i_frame_width})) begin
                    // room is width minus column, taken modulo 2^32
                    n_error_code = fwd_pkg::ST_COL;
                    n_phase      = fwd_pkg::PH_ERR;
                end else if (!i_byte[7]) begin
                    n_literal_left = run_bytes[7:0];
                    n_phase        = fwd_pkg::PH_LIT;
                end else begin
                    n_phase = fwd_pkg::PH_FILL_LO;
                end
            end
            fwd_pkg::PH_LIT: begin
                emit           = 1'b1;
                emit_action    = fwd_pkg::ACT_WRITE;
                emit_run       = 9'd1;
                emit_low       = i_byte;
                n_column       = r_column + 17'd1;
                n_literal_left = r_literal_left - 8'd1;
                if (r_literal_left == 8'd1) begin
                    n_packets_left = packets_dec;
                    if (packets_dec == 14'd0) begin
                        n_row        = row_inc;
                        n_lines_left = lines_dec;
                        n_phase      = line_phase;
                    end else begin
                        n_phase = fwd_pkg::PH_SKIP;
                    end
                end
            end
            fwd_pkg::PH_FILL_LO: begin
                n_held_byte = i_byte;
                n_phase     = fwd_pkg::PH_FILL_HI;
            end
            fwd_pkg::PH_FILL_HI: begin
                emit      = 1'b1;
                emit_low  = r_held_byte;
                emit_high = i_byte;
                if (r_held_byte == i_byte) begin
                    emit_action = fwd_pkg::ACT_FILL_BYTES;
                    emit_run    = fill_bytes;
                end else begin
                    emit_action = fwd_pkg::ACT_FILL_WORDS;
                    emit_run    = fill_words;
                end
                n_column       = r_column + {8'd0, fill_bytes};
                n_packets_left = packets_dec;
                if (packets_dec == 14'd0) begin
                    n_row        = row_inc;
                    n_lines_left = lines_dec;
                    n_phase      = line_phase;
                end else begin
                    n_phase = fwd_pkg::PH_SKIP;
                end
            end
            fwd_pkg::PH_DONE, fwd_pkg::PH_ERR: begin
                n_phase = r_phase;
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    always_comb begin
        o_result            = '0;
        o_result.has_result = emit || i_last;
        if (emit) begin
            o_result.action     = emit_action;
            o_result.address    = here_addr;
            o_result.run_length = emit_run;
            o_result.low_byte   = emit_low;
            o_result.high_byte  = emit_high;
        end
        if (i_last) begin
            o_result.chunk_end = 1'b1;
            if (n_error_code != fwd_pkg::ST_OK) begin
                o_result.status = n_error_code;
            end else if (n_phase == fwd_pkg::PH_DONE) begin
                o_result.status = fwd_pkg::ST_OK;
            end else begin
                o_result.status = fwd_pkg::ST_TRUNC;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_last)) begin
            r_phase        <= fwd_pkg::PH_CNT_LO;
            r_lines_left   <= '0;
            r_row          <= '0;
            r_column       <= '0;
            r_packets_left <= '0;
            r_held_byte    <= '0;
            r_signed_count <= '0;
            r_literal_left <= '0;
            r_error_code   <= fwd_pkg::ST_OK;
        end else if (i_fire) begin
            r_phase        <= n_phase;
            r_lines_left   <= n_lines_left;
            r_row          <= n_row;
            r_column       <= n_column;
            r_packets_left <= n_packets_left;
            r_held_byte    <= n_held_byte;
            r_signed_count <= n_signed_count;
            r_literal_left <= n_literal_left;
            r_error_code   <= n_error_code;
        end
    end

    ap_err_no_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == fwd_pkg::PH_ERR || r_phase == fwd_pkg::PH_DONE) |-> !emit)
        else $error("write decoded after error or end of lines");

    ap_err_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == fwd_pkg::PH_ERR) |-> (r_error_code != fwd_pkg::ST_OK))
        else $error("error phase without error code");

    ap_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == fwd_pkg::PH_COUNT || r_phase == fwd_pkg::PH_LIT)
            |-> (r_column <= {1'b0, i_frame_width}))
        else $error("column beyond frame width");

endmodule

`default_nettype wire

>>> rtl/flic_word_delta_decoder_unit.sv
// Top level of the FLIC word delta decoder: input register, configuration registers,
// result register. Depends on fwd_pkg, fwd_in_if, fwd_out_if and fwd_core.
`default_nettype none

// Decodes a word-oriented (SS2 style) delta chunk streamed one payload byte per
// transfer into framebuffer write commands (byte write, byte fill, word fill) at
// address row * frame_width + column. One byte is taken every cycle unless a held result
// stalls the output; the command for a byte comes out through the input register, then the result
// register. The per-byte path is one 17x16 row-times-pitch multiply plus the column
// add. Every byte with chunk_last produces a result with chunk_end set and the chunk
// status; after a bounds or tag error no further writes come out until chunk end.
// The user must write frame_width and frame_height through the configuration port only
// while no transfer is in flight; the block itself does not enforce this.
module flic_word_delta_decoder_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [0:0]                    i_cfg_index,
    input  wire logic [fwd_pkg::WidthBits-1:0] i_cfg_data,
    fwd_in_if.sink                             i_data,
    fwd_out_if.source                          o_result
);

    logic [fwd_pkg::WidthBits-1:0] r_frame_width;
    logic [fwd_pkg::WidthBits-1:0] r_frame_height;

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;
    logic             r_out_valid;
    fwd_pkg::t_result r_out;
    fwd_pkg::t_result core_result;
    logic             fire;

    assign fire         = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_data.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= fwd_pkg::FrameWidthReset;
            r_frame_height <= fwd_pkg::FrameHeightReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fwd_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                fwd_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: r_frame_width <= r_frame_width;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_data.valid && i_data.ready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_data.valid && i_data.ready) begin
            r_in_byte <= i_data.payload_byte;
            r_in_last <= i_data.chunk_last;
        end
    end

    fwd_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_byte         (r_in_byte),
        .i_last         (r_in_last),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .o_result       (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && core_result.has_result) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && core_result.has_result) begin
            r_out <= core_result;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.action     = r_out.action;
    assign o_result.address    = r_out.address;
    assign o_result.run_length = r_out.run_length;
    assign o_result.low_byte   = r_out.low_byte;
    assign o_result.high_byte  = r_out.high_byte;
    assign o_result.chunk_end  = r_out.chunk_end;
    assign o_result.status     = r_out.status;

    ap_status_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && (o_result.status != fwd_pkg::ST_OK)) |-> o_result.chunk_end)
        else $error("nonzero status outside chunk end");

    ap_none_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && (o_result.action == fwd_pkg::ACT_NONE))
            |-> (o_result.chunk_end && o_result.address == 32'd0
                 && o_result.run_length == 9'd0))
        else $error("empty command that is not a chunk end");

    ap_fill_bytes_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && (o_result.action == fwd_pkg::ACT_FILL_BYTES))
            |-> (o_result.low_byte == o_result.high_byte))
        else $error("byte fill with unequal bytes");

    ap_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_data.ready |-> (r_in_valid && o_result.valid && !o_result.ready))
        else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

>>> tb/sv/flic_word_delta_decoder_unit_checker.sv
`timescale 1ns / 1ps
// Checker for flic_word_delta_decoder_unit: follows register writes and byte transfers,
// decodes the chunk stream itself and compares every command that comes out.
// Depends on fwd_pkg, fwd_in_if and fwd_out_if.
module flic_word_delta_decoder_unit_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [0:0]                    i_cfg_index,
    input  wire logic [fwd_pkg::WidthBits-1:0] i_cfg_data,
    fwd_in_if                                  i_data,
    fwd_out_if                                 i_result,
    output int                                 o_errors,
    output int                                 o_outstanding
);

    logic [fwd_pkg::WidthBits-1:0] frame_w;
    logic [fwd_pkg::WidthBits-1:0] frame_h;

    fwd_pkg::t_phase  dec_phase;
    logic [15:0]      lines_left;
    logic [16:0]      row;
    logic [16:0]      col;
    logic [13:0]      packets_left;
    logic [7:0]       held_byte;
    logic [7:0]       run_code;
    logic [7:0]       literal_left;
    fwd_pkg::t_status err_code;

    fwd_pkg::t_result pending_cmds[$];
    int               mismatches = 0;

    function automatic void restart_chunk();
        dec_phase    = fwd_pkg::PH_CNT_LO;
        lines_left   = '0;
        row          = '0;
        col          = '0;
        packets_left = '0;
        held_byte    = '0;
        run_code     = '0;
        literal_left = '0;
        err_code     = fwd_pkg::ST_OK;
    endfunction

    function automatic void abort_chunk(fwd_pkg::t_status code);
        err_code  = code;
        dec_phase = fwd_pkg::PH_ERR;
    endfunction

    function automatic void next_line();
        row        = row + 17'd1;
        lines_left = lines_left - 16'd1;
        dec_phase  = (lines_left != 0) ? fwd_pkg::PH_OP_LO : fwd_pkg::PH_DONE;
    endfunction

    function automatic void next_packet();
        packets_left = packets_left - 14'd1;
        if (packets_left == 0) next_line();
        else dec_phase = fwd_pkg::PH_SKIP;
    endfunction

    function automatic logic [31:0] pixel_addr();
        return 32'(row) * 32'(frame_w) + 32'(col);
    endfunction

    function automatic fwd_pkg::t_result fb_command(fwd_pkg::t_action act,
                                                    logic [31:0] addr, logic [8:0] run,
                                                    logic [7:0] lo, logic [7:0] hi);
        fwd_pkg::t_result r;
        r            = '0;
        r.has_result = 1'b1;
        r.action     = act;
        r.address    = addr;
        r.run_length = run;
        r.low_byte   = lo;
        r.high_byte  = hi;
        return r;
    endfunction

    function automatic fwd_pkg::t_result decode_byte(logic [7:0] b, logic last);
        fwd_pkg::t_result r;
        logic [15:0]      op;
        logic [31:0]      next_row;
        logic [31:0]      span;
        logic [8:0]       nwords;
        r = '0;
        case (dec_phase)
            fwd_pkg::PH_CNT_LO: begin
                held_byte = b;
                dec_phase = fwd_pkg::PH_CNT_HI;
            end
            fwd_pkg::PH_CNT_HI: begin
                lines_left = {b, held_byte};
                dec_phase  = (lines_left != 0) ? fwd_pkg::PH_OP_LO : fwd_pkg::PH_DONE;
            end
            fwd_pkg::PH_OP_LO: begin
                held_byte = b;
                dec_phase = fwd_pkg::PH_OP_HI;
            end
            fwd_pkg::PH_OP_HI: begin
                op = {b, held_byte};
                case (fwd_pkg::t_tag'(op[15:14]))
                    fwd_pkg::TAG_PACKETS: begin
                        if (32'(row) >= 32'(frame_h)) abort_chunk(fwd_pkg::ST_ROW);
                        else begin
                            packets_left = op[13:0];
                            col          = '0;
                            if (packets_left == 0) next_line();
                            else dec_phase = fwd_pkg::PH_SKIP;
                        end
                    end
                    fwd_pkg::TAG_ROW_SKIP: begin
                        next_row = 32'(row) + (32'h10000 - 32'(op));
                        row      = next_row[16:0];
                        if (next_row > 32'(frame_h)) abort_chunk(fwd_pkg::ST_ROW);
                        else dec_phase = fwd_pkg::PH_OP_LO;
                    end
                    fwd_pkg::TAG_LAST_COL: begin
                        if (32'(row) >= 32'(frame_h)) abort_chunk(fwd_pkg::ST_ROW);
                        else if (frame_w == 0) abort_chunk(fwd_pkg::ST_COL);
                        else begin
                            r = fb_command(fwd_pkg::ACT_WRITE,
                                           32'(row) * 32'(frame_w) + 32'(frame_w) - 32'd1,
                                           9'd1, op[7:0], 8'd0);
                            dec_phase = fwd_pkg::PH_OP_LO;
                        end
                    end
                    default: abort_chunk(fwd_pkg::ST_TAG);
                endcase
            end
            fwd_pkg::PH_SKIP: begin
                col = col + 17'(b);
                if (32'(col) > 32'(frame_w)) abort_chunk(fwd_pkg::ST_COL);
                else dec_phase = fwd_pkg::PH_COUNT;
            end
            fwd_pkg::PH_COUNT: begin
                run_code = b;
                span     = b[7] ? 32'd2 * (32'd256 - 32'(b)) : 32'd2 * 32'(b);
                if (b == 0) next_packet();
                else if (span > 32'(frame_w) - 32'(col)) abort_chunk(fwd_pkg::ST_COL);
                else if (b[7]) dec_phase = fwd_pkg::PH_FILL_LO;
                else begin
                    literal_left = span[7:0];
                    dec_phase    = fwd_pkg::PH_LIT;
                end
            end
            fwd_pkg::PH_LIT: begin
                r            = fb_command(fwd_pkg::ACT_WRITE, pixel_addr(), 9'd1, b, 8'd0);
                col          = col + 17'd1;
                literal_left = literal_left - 8'd1;
                if (literal_left == 0) next_packet();
            end
            fwd_pkg::PH_FILL_LO: begin
                held_byte = b;
                dec_phase = fwd_pkg::PH_FILL_HI;
            end
            fwd_pkg::PH_FILL_HI: begin
                nwords = 9'd256 - 9'(run_code);
                if (held_byte == b)
                    r = fb_command(fwd_pkg::ACT_FILL_BYTES, pixel_addr(), nwords + nwords,
                                   held_byte, b);
                else
                    r = fb_command(fwd_pkg::ACT_FILL_WORDS, pixel_addr(), nwords,
                                   held_byte, b);
                col = col + 17'(nwords + nwords);
                next_packet();
            end
            default: ;
        endcase
        if (last) begin
            r.has_result = 1'b1;
            r.chunk_end  = 1'b1;
            if (err_code != fwd_pkg::ST_OK) r.status = err_code;
            else r.status = (dec_phase == fwd_pkg::PH_DONE) ? fwd_pkg::ST_OK
                                                            : fwd_pkg::ST_TRUNC;
            restart_chunk();
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        fwd_pkg::t_result want;
        fwd_pkg::t_result pred;
        if (!i_rst_n) begin
            frame_w = fwd_pkg::FrameWidthReset;
            frame_h = fwd_pkg::FrameHeightReset;
            restart_chunk();
            pending_cmds.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == fwd_pkg::CFG_FRAME_WIDTH) frame_w = i_cfg_data;
                else frame_h = i_cfg_data;
            end
            if (i_result.valid && i_result.ready) begin
                if (pending_cmds.size() == 0) begin
                    $display("%0t: command expected none, got action %0d address 0x%0h end %0b",
                             $time, i_result.action, i_result.address, i_result.chunk_end);
                    mismatches++;
                end else begin
                    want = pending_cmds.pop_front();
                    check_field("action", 32'(want.action), 32'(i_result.action));
                    check_field("address", want.address, i_result.address);
                    check_field("run_length", 32'(want.run_length), 32'(i_result.run_length));
                    check_field("low_byte", 32'(want.low_byte), 32'(i_result.low_byte));
                    check_field("high_byte", 32'(want.high_byte), 32'(i_result.high_byte));
                    check_field("chunk_end", 32'(want.chunk_end), 32'(i_result.chunk_end));
                    check_field("status", 32'(want.status), 32'(i_result.status));
                end
            end
            if (i_data.valid && i_data.ready) begin
                pred = decode_byte(i_data.payload_byte, i_data.chunk_last);
                if (pred.has_result) pending_cmds.insert(pending_cmds.size(), pred);
            end
        end
        o_errors      <= mismatches;
        o_outstanding <= pending_cmds.size();
    end

endmodule

>>> tb/sv/flic_word_delta_decoder_unit_test.sv
`timescale 1ns / 1ps
// Testbench top for flic_word_delta_decoder_unit: builds delta chunks, streams them in
// bursts, sweeps the frame size registers and reports the verdict.
// Depends on fwd_pkg, fwd_in_if, fwd_out_if, the unit and its checker.
module flic_word_delta_decoder_unit_test;

    localparam int QuietLimit      = 4000;
    localparam int LongHold        = 400;
    localparam int SettleCycles    = 4;
    localparam int BytesPerSetting = 220;
    localparam int NumSettings     = 7;
    localparam int RandomSetting   = 4;
    localparam int HoldSetting     = 2;

    localparam logic [15:0] SetWidth [NumSettings] =
        '{16'd16, 16'd0, 16'd65535, 16'd1, 16'd0, 16'd320, 16'd2};
    localparam logic [15:0] SetHeight [NumSettings] =
        '{16'd8, 16'd3, 16'd65535, 16'd0, 16'd0, 16'd200, 16'd1};

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          cfg_we;
    logic [0:0]                    cfg_index;
    logic [fwd_pkg::WidthBits-1:0] cfg_data;

    fwd_in_if  byte_ch ();
    fwd_out_if cmd_ch ();

    int fail_count;
    int cmds_pending;

    logic [7:0]                    payload_q[$];
    logic [fwd_pkg::WidthBits-1:0] cur_w;
    logic [fwd_pkg::WidthBits-1:0] cur_h;
    int                            burst_left = 0;
    int                            sent_bytes = 0;
    int                            quiet = 0;
    bit                            steady;
    bit                            hold_req = 1'b0;
    bit                            hold_done = 1'b0;

    flic_word_delta_decoder_unit dut (
        .i_clk,
        .i_rst_n,
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_data     (byte_ch),
        .o_result   (cmd_ch)
    );

    flic_word_delta_decoder_unit_checker command_check (
        .i_clk,
        .i_rst_n,
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_data       (byte_ch),
        .i_result     (cmd_ch),
        .o_errors     (fail_count),
        .o_outstanding(cmds_pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((byte_ch.valid && byte_ch.ready) || (cmd_ch.valid && cmd_ch.ready)) quiet = 0;
        else quiet++;
        if (quiet >= QuietLimit) begin
            $display("flic_word_delta_decoder_unit_test: errors");
            $finish;
        end
    end

    task automatic add_byte(logic [7:0] b);
        payload_q.insert(payload_q.size(), b);
    endtask

    task automatic put_le16(logic [15:0] w);
        add_byte(w[7:0]);
        add_byte(w[15:8]);
    endtask

    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        if (burst_left == 0) begin
            gap = steady ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                byte_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        byte_ch.valid        <= 1'b1;
        byte_ch.payload_byte <= b;
        byte_ch.chunk_last   <= last;
        do @(posedge i_clk); while (!byte_ch.ready);
        burst_left--;
        sent_bytes++;
    endtask

    task automatic send_chunk();
        steady = ($urandom_range(0, 3) == 0);
        foreach (payload_q[k]) send_byte(payload_q[k], k == payload_q.size() - 1);
    endtask

    // lower valid on the last transfer, then let the unit run dry
    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        do @(posedge i_clk); while (cmds_pending != 0);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic set_frame(logic [15:0] w, logic [15:0] h);
        cfg_we    <= 1'b1;
        cfg_index <= fwd_pkg::CFG_FRAME_WIDTH;
        cfg_data  <= w;
        @(posedge i_clk);
        cfg_index <= fwd_pkg::CFG_FRAME_HEIGHT;
        cfg_data  <= h;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        cur_w = w;
        cur_h = h;
    endtask

    // mostly legal chunks that fit the current frame, some cut, padded or garbled
    task automatic make_chunk();
        int         lines;
        int         ln;
        int         room;
        int         skip;
        int         limit;
        int         npk;
        int         span;
        int         n;
        int         kind;
        int         row_at;
        int         col_at;
        logic [7:0] fill_lo;
        payload_q.delete();
        lines = $urandom_range(0, (cur_h < 4) ? int'(cur_h) : 4);
        put_le16(16'(lines));
        row_at = 0;
        for (ln = 0; ln < lines; ln++) begin
            room = int'(cur_h) - row_at - (lines - ln);
            if (room > 0 && $urandom_range(0, 3) == 0) begin
                limit = ($urandom_range(0, 7) == 0) ? 16384 : 40;
                skip  = $urandom_range(1, (room < limit) ? room : limit);
                put_le16(16'(32'h10000 - skip));
                row_at += skip;
            end
            if (cur_w != 0 && $urandom_range(0, 4) == 0)
                put_le16({fwd_pkg::TAG_LAST_COL, 6'($urandom), 8'($urandom)});
            npk = $urandom_range(0, 3);
            put_le16({fwd_pkg::TAG_PACKETS, 14'(npk)});
            col_at = 0;
            repeat (npk) begin
                room  = int'(cur_w) - col_at;
                limit = ($urandom_range(0, 7) == 0) ? 255 : 8;
                skip  = $urandom_range(0, (room < limit) ? room : limit);
                add_byte(8'(skip));
                col_at += skip;
                span = (int'(cur_w) - col_at) / 2;
                kind = $urandom_range(0, 4);
                if (span == 0 || kind == 4) begin
                    add_byte(8'd0);
                end else if (kind < 2) begin
                    limit = ($urandom_range(0, 9) == 0) ? 127 : 6;
                    n = $urandom_range(1, (span < limit) ? span : limit);
                    add_byte(8'(n));
                    repeat (2 * n) add_byte(8'($urandom));
                    col_at += 2 * n;
                end else begin
                    n = $urandom_range(1, (span < 128) ? span : 128);
                    fill_lo = 8'($urandom);
                    add_byte(8'(256 - n));
                    add_byte(fill_lo);
                    add_byte($urandom_range(0, 1) ? fill_lo : 8'($urandom));
                    col_at += 2 * n;
                end
            end
            row_at++;
        end
        case ($urandom_range(0, 15))
            0: repeat ($urandom_range(1, payload_q.size() - 1)) void'(payload_q.pop_back());
            1: repeat ($urandom_range(1, 4)) add_byte(8'($urandom));
            2: payload_q[$urandom_range(0, payload_q.size() - 1)] = 8'($urandom);
            3: begin
                payload_q.delete();
                repeat ($urandom_range(1, 24)) add_byte(8'($urandom));
            end
            default: ;
        endcase
    endtask

    // receiver: random stall patterns, each held for a random stretch, plus one long hold
    initial begin
        int mode;
        int stretch;
        int tick;
        cmd_ch.ready <= 1'b0;
        tick = 0;
        forever begin
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(16, 160);
            repeat (stretch) begin
                @(posedge i_clk);
                tick++;
                if (hold_req && !hold_done) begin
                    cmd_ch.ready <= 1'b0;
                    repeat (LongHold) @(posedge i_clk);
                    hold_done = 1'b1;
                end
                case (mode)
                    0: cmd_ch.ready <= 1'b1;
                    1: cmd_ch.ready <= 1'($urandom_range(0, 1));
                    2: cmd_ch.ready <= ($urandom_range(0, 7) != 0);
                    default: cmd_ch.ready <= ((tick % 5) < 2);
                endcase
            end
        end
    end

    initial begin
        int s;
        int start;
        i_rst_n              <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= fwd_pkg::CFG_FRAME_WIDTH;
        cfg_data             <= '0;
        byte_ch.valid        <= 1'b0;
        byte_ch.payload_byte <= '0;
        byte_ch.chunk_last   <= 1'b0;
        cur_w = fwd_pkg::FrameWidthReset;
        cur_h = fwd_pkg::FrameHeightReset;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // no lines, then a trailing byte
        payload_q = '{8'h00, 8'h00, 8'h77};
        send_chunk();
        // row skip, last-column store, literal packet, byte fill ending the chunk
        payload_q = '{8'h01, 8'h00, 8'hFF, 8'hFF, 8'h5A, 8'h80, 8'h02, 8'h00,
                      8'h00, 8'h01, 8'hFF, 8'h00, 8'h03, 8'hFE, 8'h11, 8'h11};
        send_chunk();
        // bad tag
        payload_q = '{8'h01, 8'h00, 8'h00, 8'h40};
        send_chunk();
        // run too wide and cut short: column error wins
        payload_q = '{8'h01, 8'h00, 8'h01, 8'h00, 8'hFF, 8'h7F};
        send_chunk();
        // skip down to the frame height, then a packet line
        payload_q = '{8'h01, 8'h00, 8'h38, 8'hFF, 8'h01, 8'h00};
        send_chunk();
        wait_drained();

        for (s = 0; s < NumSettings; s++) begin
            if (s == RandomSetting)
                set_frame(16'($urandom_range(2, 1000)), 16'($urandom_range(1, 600)));
            else
                set_frame(SetWidth[s], SetHeight[s]);
            hold_req = (s == HoldSetting);
            start = sent_bytes;
            while (sent_bytes - start < BytesPerSetting) begin
                make_chunk();
                send_chunk();
            end
            wait_drained();
        end

        if (fail_count == 0)
            $display("flic_word_delta_decoder_unit_test: clean");
        else
            $display("flic_word_delta_decoder_unit_test: errors");
        $finish;
    end

endmodule
